FILE: sv/sspr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_pkg
// Shared types and constants for the servo status packet receiver.
// ----------------------------------------------------------------------------
package sspr_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Protocol constants
    localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
    localparam logic [7:0]  SUM_GOOD      = 8'hFF;
    localparam logic [7:0]  POS_SUM_START = 8'd2;
    localparam logic [7:0]  POS_STATUS    = 8'd4;
    localparam logic [7:0]  POS_PARAM_LO  = 8'd5;
    localparam logic [7:0]  POS_PARAM_HI  = 8'd6;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Operation classes carried through the queue
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
    } t_entry;

    typedef struct packed {
        logic        checksum_ok;
        logic        timed_out;
        logic [7:0]  received_count;
        logic [7:0]  status_byte;
        logic [15:0] param_word;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/sspr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_front
// Accepts input transfers, classifies the command and drops unused codes.
// ----------------------------------------------------------------------------
module sspr_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [1:0]      i_cmd,
    input  wire logic [7:0]      i_value,
    input  wire logic            i_queue_full,
    output logic                 o_push,
    output sspr_pkg::t_entry     o_entry
);

    logic    w_keep;
    sspr_pkg::t_op w_op;

    // Command decode; the unused code is accepted and discarded
    always_comb begin
        w_keep = 1'b1;
        w_op   = sspr_pkg::OP_START;
        case (i_cmd)
            sspr_pkg::CMD_START: w_op = sspr_pkg::OP_START;
            sspr_pkg::CMD_BYTE:  w_op = sspr_pkg::OP_BYTE;
            sspr_pkg::CMD_TICK:  w_op = sspr_pkg::OP_TICK;
            default:             w_keep = 1'b0;
        endcase
    end

    assign o_in_stall    = i_queue_full;
    assign o_push        = i_in_valid && !i_queue_full && w_keep;
    assign o_entry.op    = w_op;
    assign o_entry.value = i_value;

endmodule
`default_nettype wire

FILE: sv/sspr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module sspr_queue #(
    parameter int DEPTH = sspr_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sspr_pkg::t_entry i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output sspr_pkg::t_entry      o_entry,
    input  wire logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sspr_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sspr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_back
// Runs the packet reception state and drives the registered result port.
// ----------------------------------------------------------------------------
module sspr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [15:0]      i_timeout_limit,
    input  wire logic             i_q_valid,
    input  wire sspr_pkg::t_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output sspr_pkg::t_result     o_result
);

    logic        r_armed, n_armed;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_idle, n_idle;
    logic [7:0]  r_err, n_err;
    logic [7:0]  r_plo, n_plo;
    logic [7:0]  r_phi, n_phi;
    logic        r_out_valid, n_out_valid;
    sspr_pkg::t_result r_result;
    logic        w_emit, w_to;
    logic [7:0]  w_v;

    // Take an entry whenever the result slot is free or draining
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign w_v     = i_q_entry.value;

    // Execute one queued operation
    always_comb begin
        n_armed     = r_armed;
        n_count     = r_count;
        n_len       = r_len;
        n_sum       = r_sum;
        n_idle      = r_idle;
        n_err       = r_err;
        n_plo       = r_plo;
        n_phi       = r_phi;
        n_out_valid = r_out_valid && i_out_stall;
        w_emit      = 1'b0;
        w_to        = 1'b0;
        if (o_q_pop) begin
            case (i_q_entry.op)
                sspr_pkg::OP_START: begin
                    n_count = '0;
                    n_sum   = '0;
                    n_idle  = '0;
                    n_err   = '0;
                    n_plo   = '0;
                    n_phi   = '0;
                    n_len   = w_v;
                    if (w_v == '0) begin
                        w_emit = 1'b1;
                    end else begin
                        n_armed = 1'b1;
                    end
                end
                sspr_pkg::OP_BYTE: begin
                    if (r_armed) begin
                        n_idle = '0;
                        // header sync and extra header byte are dropped
                        if (!((r_count == '0 && w_v != sspr_pkg::HEADER_BYTE) ||
                              (r_count == sspr_pkg::POS_SUM_START &&
                               w_v == sspr_pkg::HEADER_BYTE))) begin
                            if (r_count >= sspr_pkg::POS_SUM_START) begin
                                n_sum = r_sum + w_v;
                            end
                            if (r_count == sspr_pkg::POS_STATUS) begin
                                n_err = w_v;
                            end
                            if (r_count == sspr_pkg::POS_PARAM_LO) begin
                                n_plo = w_v;
                            end
                            if (r_count == sspr_pkg::POS_PARAM_HI) begin
                                n_phi = w_v;
                            end
                            n_count = r_count + 1'b1;
                            if (n_count >= r_len) begin
                                w_emit = 1'b1;
                            end
                        end
                    end
                end
                sspr_pkg::OP_TICK: begin
                    if (r_armed) begin
                        if (r_idle > i_timeout_limit) begin
                            w_emit = 1'b1;
                            w_to   = 1'b1;
                        end else if (r_idle != sspr_pkg::IDLE_MAX) begin
                            n_idle = r_idle + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (w_emit) begin
            n_armed     = 1'b0;
            n_out_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_count     <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_idle      <= '0;
            r_err       <= '0;
            r_plo       <= '0;
            r_phi       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_armed     <= n_armed;
            r_count     <= n_count;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_idle      <= n_idle;
            r_err       <= n_err;
            r_plo       <= n_plo;
            r_phi       <= n_phi;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_result.checksum_ok    <= (n_sum == sspr_pkg::SUM_GOOD);
            r_result.timed_out      <= w_to;
            r_result.received_count <= n_count;
            r_result.status_byte    <= n_err;
            r_result.param_word     <= {n_phi, n_plo};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

FILE: sv/servo_status_packet_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_status_packet_receiver_top
// Status packet receiver for a half-duplex servo bus.
// ----------------------------------------------------------------------------
// A start transfer arms reception with the expected packet length; byte and
// idle tick transfers follow, and one result is delivered per packet when it
// completes, times out, or is started with length zero. The block takes one
// input transfer per cycle while the queue is not full: the front decodes the
// command into a queue of QUEUE_DEPTH entries, and the back executes one
// queued entry per cycle while its single result register is free or being
// taken. Output stall backs up the queue; the input stalls only when the
// queue is full. Write timeout_limit only while the block is idle.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver_top #(
    parameter int QUEUE_DEPTH = sspr_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_value,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_checksum_ok,
    output logic             o_timed_out,
    output logic [7:0]       o_received_count,
    output logic [7:0]       o_status_byte,
    output logic [15:0]      o_param_word,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic              w_push, w_full, w_q_valid, w_pop;
    sspr_pkg::t_entry  w_front_entry, w_q_entry;
    sspr_pkg::t_result w_result;
    logic [15:0]       r_timeout_limit;

    // Timeout register, writable every cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= sspr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_limit <= i_cfg_data;
        end
    end

    sspr_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    sspr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    sspr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_limit (r_timeout_limit),
        .i_q_valid       (w_q_valid),
        .i_q_entry       (w_q_entry),
        .o_q_pop         (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (w_result)
    );

    assign o_checksum_ok    = w_result.checksum_ok;
    assign o_timed_out      = w_result.timed_out;
    assign o_received_count = w_result.received_count;
    assign o_status_byte    = w_result.status_byte;
    assign o_param_word     = w_result.param_word;

endmodule
`default_nettype wire

FILE: sim/tb_servo_status_packet_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_status_packet_receiver_top
// Self-checking bench for the servo status packet receiver.
// ----------------------------------------------------------------------------
// Drives start, byte and idle tick transfers with random gaps on both
// channels and predicts every status report in a small tracker class. Runs a
// directed opener, a timeout at the reset limit after a byte has cleared the
// idle count, then random packets (mostly well formed, some broken or noisy)
// under several timeout limits, including a long result hold-off that backs
// up the input and a pause that drains every pending report.
// ----------------------------------------------------------------------------
module tb_servo_status_packet_receiver_top;

    // Command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         WATCHDOG_CYCLES = 2000;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         SETTLE_CYCLES   = 20;

    // Tracks the receiver state and the status reports it owes
    class packet_report_tracker;
        logic [15:0] tick_limit;
        bit          receiving;
        logic [7:0]  stored;
        logic [7:0]  target_len;
        logic [7:0]  csum;
        logic [15:0] quiet_ticks;
        logic [7:0]  err_code;
        logic [7:0]  param_lo;
        logic [7:0]  param_hi;
        sspr_pkg::t_result expected_reports[$];
        int          errors;
        int          reports;
        int          timeouts;
        int          good_sums;

        function new();
            tick_limit = sspr_pkg::TIMEOUT_RESET;
            receiving  = 1'b0;
            target_len = '0;
            start_fresh();
        endfunction

        function void start_fresh();
            stored      = '0;
            csum        = '0;
            quiet_ticks = '0;
            err_code    = '0;
            param_lo    = '0;
            param_hi    = '0;
        endfunction

        function void close_packet(bit by_timeout);
            sspr_pkg::t_result r;
            r.checksum_ok    = (csum == sspr_pkg::SUM_GOOD);
            r.timed_out      = by_timeout;
            r.received_count = stored;
            r.status_byte    = err_code;
            r.param_word     = {param_hi, param_lo};
            expected_reports.push_back(r);
            receiving = 1'b0;
        endfunction

        // Returns 0 when the block just ignores the transfer
        function bit apply_item(logic [1:0] cmd, logic [7:0] val);
            if (cmd == sspr_pkg::CMD_START) begin
                start_fresh();
                target_len = val;
                if (val == 8'd0)
                    close_packet(1'b0);
                else
                    receiving = 1'b1;
                return 1'b1;
            end
            if (!receiving || cmd == CMD_UNUSED)
                return 1'b0;
            if (cmd == sspr_pkg::CMD_BYTE) begin
                quiet_ticks = '0;
                // missing header start, or a repeated header byte
                if (stored == 8'd0 && val != sspr_pkg::HEADER_BYTE)
                    return 1'b1;
                if (stored == sspr_pkg::POS_SUM_START && val == sspr_pkg::HEADER_BYTE)
                    return 1'b1;
                if (stored >= sspr_pkg::POS_SUM_START)
                    csum += val;
                case (stored)
                    sspr_pkg::POS_STATUS:   err_code = val;
                    sspr_pkg::POS_PARAM_LO: param_lo = val;
                    sspr_pkg::POS_PARAM_HI: param_hi = val;
                    default: ;
                endcase
                stored++;
                if (stored >= target_len)
                    close_packet(1'b0);
                return 1'b1;
            end
            // idle tick
            if (quiet_ticks > tick_limit)
                close_packet(1'b1);
            else if (quiet_ticks != sspr_pkg::IDLE_MAX)
                quiet_ticks++;
            return 1'b1;
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_report(sspr_pkg::t_result got);
            sspr_pkg::t_result want;
            if (expected_reports.size() == 0) begin
                $error("report with none pending: count %0d timed_out %0d",
                       got.received_count, got.timed_out);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
            check_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
            check_field("received_count", 16'(want.received_count),
                        16'(got.received_count));
            check_field("status_byte", 16'(want.status_byte), 16'(got.status_byte));
            check_field("param_word", want.param_word, got.param_word);
            reports++;
            if (want.timed_out)
                timeouts++;
            if (want.checksum_ok)
                good_sums++;
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  in_cmd    = sspr_pkg::CMD_START;
    logic [7:0]  in_value  = 8'd0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'd0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_checksum_ok;
    logic        o_timed_out;
    logic [7:0]  o_received_count;
    logic [7:0]  o_status_byte;
    logic [15:0] o_param_word;
    logic        o_cfg_ready;

    packet_report_tracker tracker = new();

    bit      no_idle      = 1'b0;
    bit      hold_request = 1'b0;
    int      hold_left    = 0;
    int      stall_left   = 0;
    int      quiet_cycles = 0;
    int      accepted_items = 0;
    int      useful_items   = 0;
    int      ignored_items  = 0;
    sspr_pkg::t_result seen;

    servo_status_packet_receiver_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (in_cmd),
        .i_value          (in_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_checksum_ok    (o_checksum_ok),
        .o_timed_out      (o_timed_out),
        .o_received_count (o_received_count),
        .o_status_byte    (o_status_byte),
        .o_param_word     (o_param_word),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = no_idle ? 0 : pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Check every report transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            seen.checksum_ok    = o_checksum_ok;
            seen.timed_out      = o_timed_out;
            seen.received_count = o_received_count;
            seen.status_byte    = o_status_byte;
            seen.param_word     = o_param_word;
            tracker.compare_report(seen);
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("[servo_status_packet_receiver_top] ERROR");
            $finish;
        end
    end

    // One input transfer, after an optional gap
    task automatic send_item(logic [1:0] cmd, logic [7:0] val);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_value <= val;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        accepted_items++;
        if (tracker.apply_item(cmd, val))
            useful_items++;
        else
            ignored_items++;
    endtask

    // Stop sending until every pending report has come out, then settle
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (tracker.expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        tracker.tick_limit = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic idle_ticks(logic [15:0] limit);
        int n;
        n = (limit <= 16'd40) ? $urandom_range(0, int'(limit) + 3) : $urandom_range(1, 12);
        repeat (n) send_item(sspr_pkg::CMD_TICK, 8'($urandom));
    endtask

    // One random packet, usually well formed, sometimes cut short or noisy
    task automatic random_packet(logic [15:0] limit);
        int         kind;
        int         lr;
        int         len;
        int         cut;
        int         p;
        logic [7:0] run_sum;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 3))
                send_item(2'($urandom_range(1, 3)), 8'($urandom));
            return;
        end
        if (kind < 10) begin
            send_item(sspr_pkg::CMD_START, 8'd0);
            return;
        end
        lr = $urandom_range(0, 99);
        if (lr < 5)       len = $urandom_range(1, 3);
        else if (lr < 85) len = $urandom_range(4, 12);
        else if (lr < 98) len = $urandom_range(13, 40);
        else              len = $urandom_range(200, 255);
        // some packets are abandoned partway; the next start restarts
        cut = (kind < 16) ? $urandom_range(0, len - 1) : len;
        send_item(sspr_pkg::CMD_START, 8'(len));
        // line noise ahead of the header
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_item(sspr_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
        run_sum = '0;
        for (p = 0; p < cut; p++) begin
            if ($urandom_range(0, 6) == 0)
                idle_ticks(limit);
            if (p < 2)
                b = sspr_pkg::HEADER_BYTE;
            else if (p == len - 1 && $urandom_range(0, 9) < 7)
                b = sspr_pkg::SUM_GOOD - run_sum;
            else if (p == 2)
                b = 8'($urandom_range(0, 254));
            else
                b = 8'($urandom);
            // extra header byte where the id belongs
            if (p == 2 && $urandom_range(0, 9) == 0)
                send_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
            send_item(sspr_pkg::CMD_BYTE, b);
            if (p >= 2)
                run_sum += b;
        end
        if ($urandom_range(0, 19) == 0)
            idle_ticks(limit);
    endtask

    task automatic random_phase(logic [15:0] limit, int items, bit fast, bit squeeze);
        int goal;
        int half;
        bit paused;
        drain();
        write_limit(limit);
        // hold results off while a burst of zero length starts backs up the input
        if (squeeze) begin
            hold_request = 1'b1;
            no_idle      = 1'b1;
            repeat (40) send_item(sspr_pkg::CMD_START, 8'd0);
        end
        no_idle = fast;
        goal    = useful_items + items;
        half    = useful_items + items / 2;
        paused  = 1'b0;
        while (useful_items < goal) begin
            random_packet(limit);
            if (!paused && useful_items >= half) begin
                drain();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic directed_opener();
        logic [7:0] pkt [9];
        int         i;
        // full packet: extra header byte, status 0x20, params 0x1234, good sum
        pkt = '{8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h04, 8'h20, 8'h34, 8'h12, 8'h94};
        send_item(sspr_pkg::CMD_START, 8'd0);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_TICK, 8'h00);
        send_item(CMD_UNUSED, 8'hAA);
        // leading non-header byte is dropped
        send_item(sspr_pkg::CMD_START, 8'd1);
        send_item(sspr_pkg::CMD_BYTE, 8'h00);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_START, 8'd8);
        send_item(CMD_UNUSED, 8'h55);
        for (i = 0; i < 9; i++)
            send_item(sspr_pkg::CMD_BYTE, pkt[i]);
        // restart while receiving, longest length first
        send_item(sspr_pkg::CMD_START, 8'd255);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_BYTE, 8'h55);
        send_item(sspr_pkg::CMD_START, 8'd3);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_BYTE, 8'hFF);
        send_item(sspr_pkg::CMD_BYTE, 8'h00);
    endtask

    // Reset limit: a byte clears the idle count, then ticks run past the limit
    task automatic reset_limit_timeout();
        send_item(sspr_pkg::CMD_START, 8'd10);
        send_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
        repeat (40) send_item(sspr_pkg::CMD_TICK, 8'h00);
        send_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
        send_item(sspr_pkg::CMD_BYTE, 8'h07);
        repeat (int'(sspr_pkg::TIMEOUT_RESET) + 2) send_item(sspr_pkg::CMD_TICK, 8'hFF);
    endtask

    // Main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_opener();
        reset_limit_timeout();
        random_phase(16'd0, 110, 1'b0, 1'b0);
        random_phase(sspr_pkg::IDLE_MAX, 90, 1'b1, 1'b0);
        random_phase(16'd1, 110, 1'b0, 1'b1);
        random_phase(16'($urandom_range(3, 40)), 130, 1'b0, 1'b0);
        random_phase(16'd2, 90, 1'b0, 1'b0);
        random_phase(16'($urandom), 80, 1'b0, 1'b0);
        random_phase(16'd7, 110, 1'b0, 1'b0);
        drain();

        if (tracker.expected_reports.size() != 0) begin
            $error("%0d reports never arrived", tracker.expected_reports.size());
            tracker.errors++;
        end
        $display("Summary: %0d input transfers (%0d ignored), %0d reports checked",
                 accepted_items, ignored_items, tracker.reports);
        $display("Summary: %0d timeouts, %0d good checksums; limits reset, 0, 1, 2, 7, max, random",
                 tracker.timeouts, tracker.good_sums);
        if (tracker.errors == 0)
            $display("[servo_status_packet_receiver_top] OK");
        else
            $display("[servo_status_packet_receiver_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/sspr_pkg.sv
sv/sspr_front.sv
sv/sspr_queue.sv
sv/sspr_back.sv
sv/servo_status_packet_receiver_top.sv
sim/tb_servo_status_packet_receiver_top.sv
